// ===== design/tet_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tet_pkg: shared types and helpers for the touch event tracker
// Command codes, configuration register map and the axis clamp.
// ----------------------------------------------------------------------------
package tet_pkg;

	typedef enum logic [1:0] {
		FUNC_POLL   = 2'd0,
		FUNC_CANCEL = 2'd1,
		FUNC_BEGIN  = 2'd2,
		FUNC_END    = 2'd3
	} func_t;

	localparam logic [1:0] PHASE_START = 2'd0;
	localparam logic [1:0] PHASE_MOVE  = 2'd1;
	localparam logic [1:0] PHASE_END   = 2'd2;

	typedef enum logic [2:0] {
		REG_DISP_WIDTH  = 3'd0,
		REG_DISP_HEIGHT = 3'd1,
		REG_ROTATED     = 3'd2,
		REG_POLL_IVL    = 3'd3,
		REG_BACKOFF     = 3'd4,
		REG_RELEASE     = 3'd5,
		REG_FAIL_LIMIT  = 3'd6
	} reg_idx_t;

	localparam int          ADDR_W        = 5;
	localparam logic [7:0]  PACKET_MARKER = 8'hAB;
	localparam logic [7:0]  COUNT_INVALID = 8'h80;
	localparam logic [6:0]  MAX_POINTS    = 7'd5;
	localparam logic [15:0] AXIS_MAX      = 16'd4095;

	typedef struct packed {
		logic [12:0] screen_w;
		logic [12:0] screen_h;
		logic        rotated;
		logic [15:0] poll_interval_ms;
		logic [15:0] failure_backoff_ms;
		logic [7:0]  release_samples;
		logic [7:0]  failure_limit;
	} cfg_t;

	// Clamp to (size-1) taken to 16 bits, then saturate to the 12-bit range.
	function automatic logic [11:0] clamp_axis(input logic [15:0] v, input logic [12:0] size);
		logic [15:0] bound;
		logic [15:0] t;
		bound = {3'b000, size} - 16'd1;
		t = (v > bound) ? bound : v;
		return (t > AXIS_MAX) ? 12'hFFF : t[11:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/tet_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tet_regs: configuration register file
// APB-style write/read of the seven tracker settings, always ready.
// ----------------------------------------------------------------------------
module tet_regs import tet_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_w           <= 13'd480;
			cfg_q.screen_h           <= 13'd222;
			cfg_q.rotated            <= 1'b0;
			cfg_q.poll_interval_ms   <= 16'd20;
			cfg_q.failure_backoff_ms <= 16'd250;
			cfg_q.release_samples    <= 8'd2;
			cfg_q.failure_limit      <= 8'd5;
		end else if (wr_en) begin
			unique case (idx)
				REG_DISP_WIDTH:  cfg_q.screen_w           <= pwdata[12:0];
				REG_DISP_HEIGHT: cfg_q.screen_h           <= pwdata[12:0];
				REG_ROTATED:     cfg_q.rotated            <= pwdata[0];
				REG_POLL_IVL:    cfg_q.poll_interval_ms   <= pwdata[15:0];
				REG_BACKOFF:     cfg_q.failure_backoff_ms <= pwdata[15:0];
				REG_RELEASE:     cfg_q.release_samples    <= pwdata[7:0];
				REG_FAIL_LIMIT:  cfg_q.failure_limit      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DISP_WIDTH:  prdata = {19'd0, cfg_q.screen_w};
			REG_DISP_HEIGHT: prdata = {19'd0, cfg_q.screen_h};
			REG_ROTATED:     prdata = {31'd0, cfg_q.rotated};
			REG_POLL_IVL:    prdata = {16'd0, cfg_q.poll_interval_ms};
			REG_BACKOFF:     prdata = {16'd0, cfg_q.failure_backoff_ms};
			REG_RELEASE:     prdata = {24'd0, cfg_q.release_samples};
			REG_FAIL_LIMIT:  prdata = {24'd0, cfg_q.failure_limit};
			default:         prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/touch_event_tracker.sv =====
`default_nettype none
// An accepted item enters the input register, then is decoded into the
// result register. Throughput: 1 item per cycle while the result is not
// stalled; the state update is one pass of compares, a 32-bit add and
// two axis clamps between the input and result registers.
// Reset: asynchronous, clears tracking state, disables polling, loads
// config defaults; no clearing pass.
// ----------------------------------------------------------------------------
// touch_event_tracker: touch controller event tracker
// Gates polls by enable, backoff and interval, decodes packets into
// start/move/end events and handles cancel, begin and end commands.
// ----------------------------------------------------------------------------
module touch_event_tracker import tet_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// APB-style configuration
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	// command items
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        func,
	input  wire logic [31:0]       now_ms,
	input  wire logic              read_ok,
	input  wire logic [7:0]        status_byte,
	input  wire logic [7:0]        x_high_byte,
	input  wire logic [7:0]        y_high_byte,
	input  wire logic [7:0]        low_nibbles,
	input  wire logic [7:0]        count_byte,
	input  wire logic [7:0]        marker_byte,
	// result items
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   event_valid,
	output logic      [1:0]        phase,
	output logic                   touched,
	output logic      [11:0]       x_pos,
	output logic      [11:0]       y_pos,
	output logic                   ack_needed,
	output logic                   packet_used,
	output logic                   enabled_now
);

	typedef struct packed {
		func_t       func;
		logic [31:0] now_ms;
		logic        read_ok;
		logic [7:0]  status_byte;
		logic [7:0]  x_high_byte;
		logic [7:0]  y_high_byte;
		logic [7:0]  low_nibbles;
		logic [7:0]  count_byte;
		logic [7:0]  marker_byte;
	} item_t;

	typedef struct packed {
		logic        event_valid;
		logic [1:0]  phase;
		logic        touched;
		logic [11:0] x_pos;
		logic [11:0] y_pos;
		logic        ack_needed;
		logic        packet_used;
		logic        enabled_now;
	} res_t;

	cfg_t cfg;

	tet_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	logic  v_s1;
	item_t item_s1;
	logic  adv;

	// tracker state
	logic        enabled_q, touch_q;
	logic [31:0] last_poll_q, backoff_q;
	logic [7:0]  fail_cnt_q, empty_cnt_q;
	logic [11:0] held_x_q, held_y_q;

	// result register
	logic out_valid_q;
	res_t res_q;

	assign adv      = v_s1 && (!out_valid_q || !out_stall);
	assign in_stall = v_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.func        <= func_t'(func);
			item_s1.now_ms      <= now_ms;
			item_s1.read_ok     <= read_ok;
			item_s1.status_byte <= status_byte;
			item_s1.x_high_byte <= x_high_byte;
			item_s1.y_high_byte <= y_high_byte;
			item_s1.low_nibbles <= low_nibbles;
			item_s1.count_byte  <= count_byte;
			item_s1.marker_byte <= marker_byte;
		end
	end

	// next-state and result decode
	res_t        res_d;
	logic        enabled_d, touch_d;
	logic [31:0] last_poll_d, backoff_d;
	logic [7:0]  fail_cnt_d, empty_cnt_d;
	logic [11:0] held_x_d, held_y_d;

	logic        gate_ok;
	logic [31:0] since_last;
	logic        pkt_valid;
	logic [6:0]  points;
	logic        points_ok;
	logic [11:0] raw_x, raw_y;
	logic [15:0] w_m1, h_m1;
	logic [11:0] map_x, map_y;
	logic [7:0]  fail_inc, empty_inc;

	always_comb begin
		since_last = item_s1.now_ms - last_poll_q;
		gate_ok    = enabled_q && (item_s1.now_ms >= backoff_q)
			&& (since_last >= {16'd0, cfg.poll_interval_ms});

		pkt_valid = (item_s1.marker_byte == PACKET_MARKER)
			&& (item_s1.status_byte != PACKET_MARKER)
			&& (item_s1.status_byte != 8'd0)
			&& (item_s1.count_byte != COUNT_INVALID);
		points    = item_s1.count_byte[6:0];
		points_ok = pkt_valid && (points != 7'd0) && (points <= MAX_POINTS);

		raw_x = {item_s1.x_high_byte, item_s1.low_nibbles[7:4]};
		raw_y = {item_s1.y_high_byte, item_s1.low_nibbles[3:0]};
		w_m1  = {3'b000, cfg.screen_w} - 16'd1;
		h_m1  = {3'b000, cfg.screen_h} - 16'd1;
		if (cfg.rotated) begin
			map_x = clamp_axis(w_m1 - {4'd0, raw_y}, cfg.screen_w);
			map_y = clamp_axis({4'd0, raw_x}, cfg.screen_h);
		end else begin
			map_x = clamp_axis({4'd0, raw_y}, cfg.screen_w);
			map_y = clamp_axis(h_m1 - {4'd0, raw_x}, cfg.screen_h);
		end

		fail_inc  = (fail_cnt_q == 8'hFF) ? 8'hFF : fail_cnt_q + 8'd1;
		empty_inc = (empty_cnt_q == 8'hFF) ? 8'hFF : empty_cnt_q + 8'd1;

		res_d       = '0;
		enabled_d   = enabled_q;
		touch_d     = touch_q;
		last_poll_d = last_poll_q;
		backoff_d   = backoff_q;
		fail_cnt_d  = fail_cnt_q;
		empty_cnt_d = empty_cnt_q;
		held_x_d    = held_x_q;
		held_y_d    = held_y_q;

		case (item_s1.func)
			FUNC_CANCEL, FUNC_BEGIN, FUNC_END: begin
				touch_d     = 1'b0;
				last_poll_d = 32'd0;
				backoff_d   = 32'd0;
				fail_cnt_d  = 8'd0;
				empty_cnt_d = 8'd0;
				if (item_s1.func == FUNC_BEGIN) begin
					held_x_d  = 12'd0;
					held_y_d  = 12'd0;
					enabled_d = item_s1.read_ok;
				end else if (item_s1.func == FUNC_END) begin
					enabled_d = 1'b0;
				end
			end
			FUNC_POLL: begin
				if (gate_ok) begin
					last_poll_d = item_s1.now_ms;
					if (!item_s1.read_ok) begin
						backoff_d  = item_s1.now_ms + {16'd0, cfg.failure_backoff_ms};
						fail_cnt_d = fail_inc;
						if (fail_inc >= cfg.failure_limit) enabled_d = 1'b0;
					end else begin
						res_d.packet_used = 1'b1;
						fail_cnt_d        = 8'd0;
						if (!points_ok) begin
							res_d.ack_needed = 1'b1;
							if (touch_q) begin
								empty_cnt_d = empty_inc;
								// enough empty samples: release at the held position
								if (empty_inc >= cfg.release_samples) begin
									touch_d           = 1'b0;
									empty_cnt_d       = 8'd0;
									res_d.event_valid = 1'b1;
									res_d.phase       = PHASE_END;
									res_d.x_pos       = held_x_q;
									res_d.y_pos       = held_y_q;
								end
							end
						end else begin
							backoff_d         = 32'd0;
							empty_cnt_d       = 8'd0;
							res_d.event_valid = 1'b1;
							res_d.touched     = 1'b1;
							res_d.phase       = touch_q ? PHASE_MOVE : PHASE_START;
							res_d.x_pos       = map_x;
							res_d.y_pos       = map_y;
							touch_d           = 1'b1;
							held_x_d          = map_x;
							held_y_d          = map_y;
						end
					end
				end
			end
		endcase
		res_d.enabled_now = enabled_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q   <= 1'b0;
			touch_q     <= 1'b0;
			last_poll_q <= 32'd0;
			backoff_q   <= 32'd0;
			fail_cnt_q  <= 8'd0;
			empty_cnt_q <= 8'd0;
			held_x_q    <= 12'd0;
			held_y_q    <= 12'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				enabled_q   <= enabled_d;
				touch_q     <= touch_d;
				last_poll_q <= last_poll_d;
				backoff_q   <= backoff_d;
				fail_cnt_q  <= fail_cnt_d;
				empty_cnt_q <= empty_cnt_d;
				held_x_q    <= held_x_d;
				held_y_q    <= held_y_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_q <= res_d;
	end

	assign out_valid   = out_valid_q;
	assign event_valid = res_q.event_valid;
	assign phase       = res_q.phase;
	assign touched     = res_q.touched;
	assign x_pos       = res_q.x_pos;
	assign y_pos       = res_q.y_pos;
	assign ack_needed  = res_q.ack_needed;
	assign packet_used = res_q.packet_used;
	assign enabled_now = res_q.enabled_now;

	a_end_disables: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.func == FUNC_END |=> !enabled_q)
		else $error("end command left polling enabled");

	a_end_untouched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.event_valid && res_q.phase == PHASE_END |-> !res_q.touched)
		else $error("end event reported as touched");

	a_touch_used: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.touched |-> res_q.packet_used && res_q.event_valid)
		else $error("touch event without a consumed packet");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_d.event_valid && res_d.phase == PHASE_END |=> !touch_q && empty_cnt_q == 8'd0)
		else $error("release left touch tracking active");

endmodule
`default_nettype wire
